@@ rtl/sud_pkg.sv @@
// Shared types and constants for the signed/unsigned divider.
`default_nettype none

package sud_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ABS_A,
    S_ABS_B,
    S_DIV,
    S_NEG_Q,
    S_NEG_R,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ABS_A,
    OP_ABS_B,
    OP_STEP,
    OP_NEG_Q,
    OP_NEG_R
  } alu_op_t;

  typedef struct packed {
    logic    load;
    alu_op_t op;
  } ctl_t;

  typedef struct packed {
    logic div_zero;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/signed_unsigned_divider.sv @@
// Top level of the signed/unsigned restoring divider.
//
// Input channel: in_valid/in_stall with in_func (0 unsigned, 1 signed),
// in_dividend_bits and in_divisor_bits. Result channel: out_valid/out_stall
// with out_quotient_bits, out_remainder_bits and out_zero_divisor.
// A request is taken only while the block is idle; in_stall is high otherwise.
// After acceptance the sequencer runs operand sign fix-up (S_ABS_A, S_ABS_B),
// shift-subtract in S_DIV with one quotient bit per cycle, and result sign
// fix-up (S_NEG_Q, S_NEG_R), all on one shared WIDTH+1 bit subtractor, then
// raises out_valid in S_DONE; the result can be taken while out_valid is high.
// A zero divisor skips the iterations and shows its result in the cycle after
// acceptance.
// A new request is not taken until the last result has been taken.
// The result holds in its registers while out_stall is high; the next
// request is taken the cycle after the result is taken.
// Reset (rst_n, synchronous, active low) returns the sequencer to idle and
// drops any request in flight.
`default_nettype none

module signed_unsigned_divider import sud_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_func,
  input  wire logic [WIDTH-1:0] in_dividend_bits,
  input  wire logic [WIDTH-1:0] in_divisor_bits,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [WIDTH-1:0]      out_quotient_bits,
  output logic [WIDTH-1:0]      out_remainder_bits,
  output logic                  out_zero_divisor
);

  ctl_t ctl;
  sts_t sts;

  sud_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  sud_datapath u_datapath (
    .clk                (clk),
    .ctl                (ctl),
    .in_func            (in_func),
    .in_dividend_bits   (in_dividend_bits),
    .in_divisor_bits    (in_divisor_bits),
    .sts                (sts),
    .out_quotient_bits  (out_quotient_bits),
    .out_remainder_bits (out_remainder_bits),
    .out_zero_divisor   (out_zero_divisor)
  );

  a_nonzero_not_early: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_divisor_bits != '0) |=> !out_valid)
    else $error("result shown right after a nonzero-divisor request");

  a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_divisor_bits == '0) |=>
      (out_valid && out_zero_divisor && out_quotient_bits == '1))
    else $error("zero divisor result missing or wrong");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated after it was taken");

  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while a result is pending");

endmodule

`default_nettype wire

@@ rtl/sud_datapath.sv @@
// Operand registers and the shared subtractor of the divider.
`default_nettype none

module sud_datapath import sud_pkg::*; (
  input  wire logic             clk,
  input  wire ctl_t             ctl,
  input  wire logic             in_func,
  input  wire logic [WIDTH-1:0] in_dividend_bits,
  input  wire logic [WIDTH-1:0] in_divisor_bits,
  output sts_t                  sts,
  output logic [WIDTH-1:0]      out_quotient_bits,
  output logic [WIDTH-1:0]      out_remainder_bits,
  output logic                  out_zero_divisor
);

  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] div_r, div_nxt;
  logic             sa_r, sa_nxt;
  logic             sb_r, sb_nxt;
  logic             zero_r, zero_nxt;

  logic [WIDTH:0]   alu_x;
  logic [WIDTH:0]   alu_y;
  logic [WIDTH:0]   alu_diff;

  assign sts.div_zero = (in_divisor_bits == '0);

  // Operand select for the one subtractor
  always_comb begin
    alu_x = '0;
    alu_y = '0;
    case (ctl.op)
      OP_ABS_A: alu_y = {1'b0, quo_r};
      OP_ABS_B: alu_y = {1'b0, div_r};
      OP_STEP: begin
        alu_x = {rem_r, quo_r[WIDTH-1]};
        alu_y = {1'b0, div_r};
      end
      OP_NEG_Q: alu_y = {1'b0, quo_r};
      OP_NEG_R: alu_y = {1'b0, rem_r};
      default: begin
        alu_x = '0;
        alu_y = '0;
      end
    endcase
  end

  assign alu_diff = alu_x - alu_y;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    sa_nxt   = sa_r;
    sb_nxt   = sb_r;
    zero_nxt = zero_r;
    if (ctl.load) begin
      div_nxt  = in_divisor_bits;
      sa_nxt   = in_func & in_dividend_bits[WIDTH-1];
      sb_nxt   = in_func & in_divisor_bits[WIDTH-1];
      zero_nxt = sts.div_zero;
      if (sts.div_zero) begin
        quo_nxt = '1;
        rem_nxt = in_dividend_bits;
      end else begin
        quo_nxt = in_dividend_bits;
        rem_nxt = '0;
      end
    end else begin
      case (ctl.op)
        OP_ABS_A: if (sa_r) quo_nxt = alu_diff[WIDTH-1:0];
        OP_ABS_B: if (sb_r) div_nxt = alu_diff[WIDTH-1:0];
        OP_STEP: begin
          // keep the trial difference when it did not borrow
          if (!alu_diff[WIDTH]) begin
            rem_nxt = alu_diff[WIDTH-1:0];
            quo_nxt = {quo_r[WIDTH-2:0], 1'b1};
          end else begin
            rem_nxt = alu_x[WIDTH-1:0];
            quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
          end
        end
        OP_NEG_Q: if (sa_r ^ sb_r) quo_nxt = alu_diff[WIDTH-1:0];
        OP_NEG_R: if (sa_r) rem_nxt = alu_diff[WIDTH-1:0];
        default: begin
          quo_nxt = quo_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    sa_r   <= sa_nxt;
    sb_r   <= sb_nxt;
    zero_r <= zero_nxt;
  end

  assign out_quotient_bits  = quo_r;
  assign out_remainder_bits = rem_r;
  assign out_zero_divisor   = zero_r;

endmodule

`default_nettype wire

@@ rtl/sud_ctrl.sv @@
// Sequencer of the divider: state machine and bit counter.
`default_nettype none

module sud_ctrl import sud_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign accept = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // a zero divisor needs no iterations
          state_nxt = sts.div_zero ? S_DONE : S_ABS_A;
        end
      end
      S_ABS_A: state_nxt = S_ABS_B;
      S_ABS_B: begin
        state_nxt = S_DIV;
        cnt_nxt   = CNT_W'(WIDTH - 1);
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_NEG_Q;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_NEG_Q: state_nxt = S_NEG_R;
      S_NEG_R: state_nxt = S_DONE;
      S_DONE:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    ctl.load  = 1'b0;
    ctl.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      S_ABS_A: ctl.op = OP_ABS_A;
      S_ABS_B: ctl.op = OP_ABS_B;
      S_DIV:   ctl.op = OP_STEP;
      S_NEG_Q: ctl.op = OP_NEG_Q;
      S_NEG_R: ctl.op = OP_NEG_R;
      S_DONE:  out_valid = 1'b1;
      default: ctl.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire
